/* rtl/olt_pkg.sv */
// shared constants, codes and types for the ordered list table
`default_nettype none
package olt_pkg;

	localparam int DEPTH = 16;
	localparam int WIDTH = 32;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// field widths of the request and response words
	localparam int FUNC_W  = 2;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int ST_W    = 2;
	localparam int DATA_W  = 32;
	localparam int FIDX_W  = 4;
	localparam int COUNT_W = 5;

	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] OP_GET    = 2'd2;
	localparam logic [FUNC_W-1:0] OP_LOCATE = 2'd3;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_MISS   = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [IDX_W-1:0] pos0;
		logic [WIDTH-1:0] key;
		logic [CNT_W-1:0] count;
	} cell_cmd_t;

	typedef struct packed {
		logic [WIDTH-1:0] rd_word;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
	} pick_t;

endpackage
`default_nettype wire

/* rtl/olt_req_if.sv */
// request channel: operation, position and value
`default_nettype none
interface olt_req_if import olt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink   (input valid, input func, input position, input value, output ready);
endinterface
`default_nettype wire

/* rtl/olt_rsp_if.sv */
// response channel: status, data, found index and count
`default_nettype none
interface olt_rsp_if import olt_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic [DATA_W-1:0]  data;
	logic [FIDX_W-1:0]  found_index;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output status, output data, output found_index,
		output count, input ready);
	modport sink   (input valid, input status, input data, input found_index,
		input count, output ready);
endinterface
`default_nettype wire

/* rtl/olt_cell.sv */
// one slot of the list: holds a word, shifts with its neighbours, compares
`default_nettype none
module olt_cell import olt_pkg::*; (
	input  wire logic             clk,
	input  wire logic [IDX_W-1:0] idx,
	input  wire cell_cmd_t        cmd,
	input  wire logic [WIDTH-1:0] left,
	input  wire logic [WIDTH-1:0] right,
	output logic      [WIDTH-1:0] word,
	output logic                  match
);

	logic [WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && idx > cmd.pos0) begin
			word_q <= left;
		end else if (cmd.ins && idx == cmd.pos0) begin
			word_q <= cmd.key;
		end else if (cmd.rem && idx >= cmd.pos0) begin
			word_q <= right;
		end
	end

	assign word  = word_q;
	assign match = (CNT_W'(idx) < cmd.count) && (word_q == cmd.key);

endmodule
`default_nettype wire

/* rtl/olt_pick.sv */
// read select and first-match encoder across the cell chain
`default_nettype none
module olt_pick import olt_pkg::*; (
	input  wire logic [WIDTH-1:0] words [DEPTH],
	input  wire logic [DEPTH-1:0] match,
	input  wire logic [IDX_W-1:0] rd_idx,
	output pick_t                 pick
);

	always_comb begin
		pick.rd_word = words[rd_idx];
		pick.hit     = |match;
		pick.hit_idx = '0;
		// lowest matching slot wins
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				pick.hit_idx = IDX_W'(i);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/ordered_list_table.sv */
// ordered list table: fixed-capacity list of words in a chain of slot cells
// response: the response word is registered when the request is accepted
// throughput: one request per cycle unless rsp.ready stalls; every operation, shifts
//   included, completes in the accept cycle because all cells move in parallel to their neighbours
// reset: arst_n clears the fill count and the response valid; slot contents are not reset
`default_nettype none
module ordered_list_table import olt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	olt_req_if.sink   req,
	olt_rsp_if.source rsp
);

	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [DATA_W-1:0] data_q;
	logic [FIDX_W-1:0] fidx_q;

	logic              accept;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic [IDX_W-1:0]  rd_idx;
	logic [ST_W-1:0]   status_d;
	logic [DATA_W-1:0] data_d;
	logic [FIDX_W-1:0] fidx_d;
	logic [CNT_W-1:0]  count_d;
	logic              do_ins;
	logic              do_rem;
	cell_cmd_t         cmd;
	pick_t             pick;
	logic [WIDTH-1:0]  words [DEPTH];
	logic [DEPTH-1:0]  match;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign pos_c  = CMP_W'(req.position);
	assign cnt_c  = CMP_W'(count_q);
	assign rd_idx = (req.func == OP_GET) ? IDX_W'(req.position)
		: IDX_W'(req.position - POS_W'(1));

	always_comb begin
		status_d = ST_OK;
		data_d   = '0;
		fidx_d   = '0;
		count_d  = count_q;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		unique case (req.func)
			OP_INSERT: begin
				if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) begin
					status_d = ST_BADPOS;
				end else if (count_q == CNT_W'(DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_c == '0 || pos_c > cnt_c) begin
					status_d = ST_BADPOS;
				end else begin
					do_rem  = 1'b1;
					data_d  = DATA_W'(pick.rd_word);
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_GET: begin
				if (pos_c >= cnt_c) begin
					status_d = ST_BADPOS;
				end else begin
					data_d = DATA_W'(pick.rd_word);
				end
			end
			OP_LOCATE: begin
				if (pick.hit) begin
					fidx_d = FIDX_W'(pick.hit_idx);
				end else begin
					status_d = ST_MISS;
				end
			end
			default: status_d = ST_BADPOS;
		endcase
	end

	assign cmd.ins   = accept && do_ins;
	assign cmd.rem   = accept && do_rem;
	assign cmd.pos0  = IDX_W'(req.position - POS_W'(1));
	assign cmd.key   = WIDTH'(req.value);
	assign cmd.count = count_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WIDTH-1:0] left_w;
		logic [WIDTH-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = words[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = words[g+1];
		end

		olt_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.word  (words[g]),
			.match (match[g])
		);
	end

	olt_pick u_pick (
		.words  (words),
		.match  (match),
		.rd_idx (rd_idx),
		.pick   (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			data_q   <= data_d;
			fidx_q   <= fidx_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.data        = data_q;
	assign rsp.found_index = fidx_q;
	assign rsp.count       = COUNT_W'(count_q);

endmodule
`default_nettype wire

/* rtl/olt_checker.sv */
// port-level checks for the ordered list table, bound to the top level
`default_nettype none
module olt_checker import olt_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic [ST_W-1:0]    rsp_status,
	input wire logic [DATA_W-1:0]  rsp_data,
	input wire logic [FIDX_W-1:0]  rsp_found_index,
	input wire logic [COUNT_W-1:0] rsp_count
);

	// a stalled response keeps its valid, status and data
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data))
		else $error("response word changed while stalled");

	// every accepted request yields a response on the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request gave no response");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(DEPTH))
		else $error("list full reported below capacity");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_MISS |-> rsp_found_index == '0 && rsp_data == '0)
		else $error("locate miss carries nonzero fields");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= COUNT_W'(DEPTH))
		else $error("count above capacity");

endmodule

bind ordered_list_table olt_checker u_olt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_data        (rsp.data),
	.rsp_found_index (rsp.found_index),
	.rsp_count       (rsp.count)
);
`default_nettype wire
